### sv/mmc_pkg.sv
// Shared types and constants for the model matrix compose block.
package mmc_pkg;

    localparam int FULL_TURN    = 23040;
    localparam int QUARTER_TURN = 5760;
    localparam int ROWS         = 4;

    localparam logic [1:0] LAST_ROW = 2'd3;

    // x = r * pi / 11520 in Q30, split as r * 292817 + floor(r * 3793 / 5760)
    localparam logic [18:0] X_INT_MUL    = 19'd292817;
    localparam logic [11:0] X_FRAC_MUL   = 12'd3793;
    localparam logic [18:0] X_FRAC_RECIP = 19'd372828;
    localparam int          X_FRAC_K     = 24;

    // Taylor step k divides by (2k)(2k+1) = 2^shift * odd, odd by reciprocal
    localparam int TAY_STEPS = 6;
    localparam int TAY_SHIFT [0:5] = '{1, 2, 1, 3, 1, 2};
    localparam int TAY_K     [0:5] = '{32, 31, 32, 26, 25, 20};
    localparam logic [31:0] TAY_RECIP [0:5] = '{
        32'd1431655766, 32'd429496730, 32'd204522253,
        32'd7456541,    32'd610081,    32'd26887
    };

    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

    // sine and cosine per axis (Q1.15), translation and scale (Q16.16)
    typedef struct packed {
        logic [2:0][15:0] sn;
        logic [2:0][15:0] cs;
        logic [2:0][31:0] move;
        logic [2:0][31:0] scl;
    } trig_t;

endpackage

### sv/mmc_if.sv
// Valid/ready channel interfaces for item input and row output.
interface mmc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
    logic signed [31:0] move_z;
    logic signed [31:0] stretch_x;
    logic signed [31:0] stretch_y;
    logic signed [31:0] stretch_z;

    modport source (
        output valid, angle_x, angle_y, angle_z, move_x, move_y, move_z,
               stretch_x, stretch_y, stretch_z,
        input  ready
    );
    modport sink (
        input  valid, angle_x, angle_y, angle_z, move_x, move_y, move_z,
               stretch_x, stretch_y, stretch_z,
        output ready
    );
endinterface

interface mmc_out_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  row_index;
    logic signed [31:0] entry_0;
    logic signed [31:0] entry_1;
    logic signed [31:0] entry_2;
    logic signed [31:0] entry_3;
    logic               final_row;

    modport source (
        output valid, row_index, entry_0, entry_1, entry_2, entry_3, final_row,
        input  ready
    );
    modport sink (
        input  valid, row_index, entry_0, entry_1, entry_2, entry_3, final_row,
        output ready
    );
endinterface

### sv/mmc_qsin.sv
// Pipelined quarter-wave sine: Q30 Taylor series to x^13, rounded to Q1.15.
module mmc_qsin (
    input  logic        clk,
    input  logic        en,
    input  logic [12:0] r,
    output logic [14:0] value
);

    logic [30:0]        pa_reg;
    logic [24:0]        pb_reg;
    logic [30:0]        x_reg;
    logic [36:0]        frac_prod;
    logic [61:0]        xx;

    logic [30:0]        term_reg [0:6];
    logic [31:0]        x2_reg   [0:6];
    logic signed [32:0] sum_reg  [0:6];

    logic [31:0]        n_reg    [1:6];
    logic [31:0]        x2a_reg  [1:6];
    logic signed [32:0] suma_reg [1:6];

    logic [33:0]        rnd;
    logic [14:0]        value_next;
    logic [14:0]        value_reg;

    assign frac_prod = 37'(pb_reg[24:7]) * 37'(mmc_pkg::X_FRAC_RECIP);
    assign xx        = 62'(x_reg) * 62'(x_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg      <= 31'(32'(r) * 32'(mmc_pkg::X_INT_MUL));
            pb_reg      <= 25'(r) * 25'(mmc_pkg::X_FRAC_MUL);
            x_reg       <= pa_reg + 31'(frac_prod[mmc_pkg::X_FRAC_K +: 12]);
            term_reg[0] <= x_reg;
            x2_reg[0]   <= xx[61:30];
            sum_reg[0]  <= $signed({2'b00, x_reg});
        end
    end

    for (genvar k = 1; k <= mmc_pkg::TAY_STEPS; k++)
    begin : g_step
        localparam int          SH = mmc_pkg::TAY_SHIFT[k-1];
        localparam int          KS = mmc_pkg::TAY_K[k-1];
        localparam logic [31:0] RC = mmc_pkg::TAY_RECIP[k-1];

        logic [62:0] prod;
        logic [35:0] wide;
        logic [63:0] qprod;
        logic [30:0] q;

        assign prod  = 63'(term_reg[k-1]) * 63'(x2_reg[k-1]);
        assign wide  = {3'b000, prod[62:30]};
        assign qprod = 64'(n_reg[k]) * 64'(RC);
        assign q     = qprod[KS +: 31];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k]    <= wide[SH +: 32];
                x2a_reg[k]  <= x2_reg[k-1];
                suma_reg[k] <= sum_reg[k-1];
                term_reg[k] <= q;
                x2_reg[k]   <= x2a_reg[k];
                // odd steps subtract, even steps add
                if (k % 2 == 1)
                begin
                    sum_reg[k] <= suma_reg[k] - $signed({2'b00, q});
                end
                else
                begin
                    sum_reg[k] <= suma_reg[k] + $signed({2'b00, q});
                end
            end
        end
    end

    always_comb
    begin
        rnd = 34'(sum_reg[6]) + 34'd16384;
        if (sum_reg[6] < 0)
        begin
            value_next = '0;
        end
        else if (rnd[33:15] > 19'd32767)
        begin
            value_next = 15'h7fff;
        end
        else
        begin
            value_next = rnd[29:15];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

### sv/mmc_trig.sv
// Angle reduction, six sine lanes and quadrant sign stage.
module mmc_trig (
    input  logic               clk,
    input  logic               rst_n,
    mmc_in_if.sink             items,
    output logic               t_valid,
    input  logic               t_ready,
    output mmc_pkg::trig_t     t_data
);

    localparam int LANE_DEPTH = 16;
    localparam int DEPTH      = LANE_DEPTH + 3;

    typedef struct packed {
        logic [2:0][1:0]  quad;
        logic [2:0][31:0] move;
        logic [2:0][31:0] scl;
    } side_t;

    logic               en;
    logic [DEPTH-1:0]   v_reg;
    logic [DEPTH-1:0]   v_next;

    logic [2:0][15:0]   ang;
    logic [2:0][14:0]   a_reg;
    logic [2:0][31:0]   mv_reg;
    logic [2:0][31:0]   sc_reg;
    logic [2:0][12:0]   r_reg;
    logic [2:0][12:0]   rc_reg;
    side_t              f1_side_reg;
    side_t              side_reg [0:LANE_DEPTH-1];
    logic [5:0][14:0]   lane_val;
    mmc_pkg::trig_t     out_reg;
    mmc_pkg::trig_t     out_next;

    function automatic logic [14:0] wrap_angle(input logic signed [15:0] x);
        logic signed [17:0] w;
        logic signed [17:0] res;
        w = 18'(x);
        priority if (w < -18'sd23040)
        begin
            res = w + 18'sd46080;
        end
        else if (w < 18'sd0)
        begin
            res = w + 18'sd23040;
        end
        else if (w >= 18'sd23040)
        begin
            res = w - 18'sd23040;
        end
        else
        begin
            res = w;
        end
        return res[14:0];
    endfunction

    assign en          = !v_reg[DEPTH-1] || t_ready;
    assign items.ready = en;
    assign v_next      = {v_reg[DEPTH-2:0], items.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    assign ang = {items.angle_z, items.angle_y, items.angle_x};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_reg[i] <= wrap_angle($signed(ang[i]));
            end
            mv_reg <= {items.move_z, items.move_y, items.move_x};
            sc_reg <= {items.stretch_z, items.stretch_y, items.stretch_x};

            // split into quadrant and rest
            for (int i = 0; i < 3; i++)
            begin
                priority if (a_reg[i] >= 15'd17280)
                begin
                    f1_side_reg.quad[i] <= 2'd3;
                    r_reg[i] <= 13'(a_reg[i] - 15'd17280);
                    rc_reg[i] <= 13'(15'd23040 - a_reg[i]);
                end
                else if (a_reg[i] >= 15'd11520)
                begin
                    f1_side_reg.quad[i] <= 2'd2;
                    r_reg[i] <= 13'(a_reg[i] - 15'd11520);
                    rc_reg[i] <= 13'(15'd17280 - a_reg[i]);
                end
                else if (a_reg[i] >= 15'd5760)
                begin
                    f1_side_reg.quad[i] <= 2'd1;
                    r_reg[i] <= 13'(a_reg[i] - 15'd5760);
                    rc_reg[i] <= 13'(15'd11520 - a_reg[i]);
                end
                else
                begin
                    f1_side_reg.quad[i] <= 2'd0;
                    r_reg[i] <= 13'(a_reg[i]);
                    rc_reg[i] <= 13'(15'd5760 - a_reg[i]);
                end
            end
            f1_side_reg.move <= mv_reg;
            f1_side_reg.scl  <= sc_reg;

            side_reg[0] <= f1_side_reg;
            for (int s = 1; s < LANE_DEPTH; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
            out_reg <= out_next;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_axis
        mmc_qsin u_sin (
            .clk   (clk),
            .en    (en),
            .r     (r_reg[i]),
            .value (lane_val[2*i])
        );
        mmc_qsin u_cos (
            .clk   (clk),
            .en    (en),
            .r     (rc_reg[i]),
            .value (lane_val[2*i+1])
        );
    end

    always_comb
    begin
        logic [15:0] sr;
        logic [15:0] cr;
        out_next      = '0;
        out_next.move = side_reg[LANE_DEPTH-1].move;
        out_next.scl  = side_reg[LANE_DEPTH-1].scl;
        for (int i = 0; i < 3; i++)
        begin
            sr = {1'b0, lane_val[2*i]};
            cr = {1'b0, lane_val[2*i+1]};
            unique case (side_reg[LANE_DEPTH-1].quad[i])
                2'd0:
                begin
                    out_next.sn[i] = sr;
                    out_next.cs[i] = cr;
                end
                2'd1:
                begin
                    out_next.sn[i] = cr;
                    out_next.cs[i] = 16'(-sr);
                end
                2'd2:
                begin
                    out_next.sn[i] = 16'(-sr);
                    out_next.cs[i] = 16'(-cr);
                end
                default:
                begin
                    out_next.sn[i] = 16'(-cr);
                    out_next.cs[i] = sr;
                end
            endcase
        end
    end

    assign t_valid = v_reg[DEPTH-1];
    assign t_data  = out_reg;

endmodule

### sv/mmc_rows.sv
// Row sequencer and pipelined row datapath with output register.
module mmc_rows (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               t_valid,
    output logic               t_ready,
    input  mmc_pkg::trig_t     t_data,
    mmc_out_if.source          rows
);

    typedef struct packed {
        logic [1:0]       row;
        logic [31:0]      move;
        logic [2:0][31:0] scl;
    } info_t;

    logic               en;
    logic               issue;
    logic               take;
    mmc_pkg::trig_t     hold_reg;
    logic [1:0]         row_reg;
    logic               busy_reg;
    logic [3:0]         rv_reg;
    logic               out_v_reg;

    logic signed [16:0] u [3];
    logic signed [16:0] v [3];
    logic signed [16:0] w [3];
    logic signed [16:0] f [3];
    logic signed [16:0] g [3];
    info_t              info_next;

    logic signed [33:0] t_reg   [3];
    logic signed [33:0] p_reg   [3];
    logic signed [16:0] w_reg   [3];
    logic signed [51:0] rot_reg [3];
    logic signed [33:0] rq_reg  [3];
    logic signed [65:0] pr_reg  [3];
    info_t              i1_reg;
    info_t              i2_reg;
    info_t              i3_reg;
    info_t              i4_reg;

    logic [1:0]         row_out_reg;
    logic [3:0][31:0]   ent_reg;
    logic [3:0][31:0]   ent_next;

    function automatic logic signed [33:0] round_q15(input logic signed [51:0] x);
        logic signed [51:0] t;
        t = x + ((x < 0) ? 52'sd16383 : 52'sd16384);
        return t[48:15];
    endfunction

    function automatic logic [31:0] round_sat_q30(input logic signed [65:0] x);
        logic signed [65:0] t;
        logic signed [35:0] s;
        t = x + ((x < 0) ? 66'sd536870911 : 66'sd536870912);
        s = t[65:30];
        priority if (s > 36'sd2147483647)
        begin
            return 32'h7fffffff;
        end
        else if (s < -36'sd2147483648)
        begin
            return 32'h80000000;
        end
        else
        begin
            return s[31:0];
        end
    endfunction

    assign en      = !out_v_reg || rows.ready;
    assign issue   = busy_reg && en;
    assign t_ready = !busy_reg || (row_reg == mmc_pkg::LAST_ROW && en);
    assign take    = t_valid && t_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            row_reg   <= '0;
            rv_reg    <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                busy_reg <= 1'b1;
                row_reg  <= '0;
            end
            else if (issue)
            begin
                row_reg <= row_reg + 2'd1;
                if (row_reg == mmc_pkg::LAST_ROW)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (en)
            begin
                rv_reg    <= {rv_reg[2:0], issue};
                out_v_reg <= rv_reg[3];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_reg <= t_data;
        end
    end

    // pick operands: rot = u*v*w + f*g*2^15
    always_comb
    begin
        logic signed [16:0] sx, cx, sy, cy, sz, cz;
        sx = 17'($signed(hold_reg.sn[0]));
        cx = 17'($signed(hold_reg.cs[0]));
        sy = 17'($signed(hold_reg.sn[1]));
        cy = 17'($signed(hold_reg.cs[1]));
        sz = 17'($signed(hold_reg.sn[2]));
        cz = 17'($signed(hold_reg.cs[2]));
        for (int j = 0; j < 3; j++)
        begin
            u[j] = '0;
            v[j] = '0;
            w[j] = '0;
            f[j] = '0;
            g[j] = '0;
        end
        info_next.row  = row_reg;
        info_next.scl  = hold_reg.scl;
        info_next.move = '0;
        unique case (row_reg)
            2'd0:
            begin
                info_next.move = hold_reg.move[0];
                f[0] = cy;
                g[0] = cz;
                f[1] = -cy;
                g[1] = sz;
                f[2] = sy;
                g[2] = 17'sd32768;
            end
            2'd1:
            begin
                info_next.move = hold_reg.move[1];
                u[0] = sx;
                v[0] = sy;
                w[0] = cz;
                f[0] = cx;
                g[0] = sz;
                u[1] = -sx;
                v[1] = sy;
                w[1] = sz;
                f[1] = cx;
                g[1] = cz;
                f[2] = -sx;
                g[2] = cy;
            end
            2'd2:
            begin
                info_next.move = hold_reg.move[2];
                u[0] = -cx;
                v[0] = sy;
                w[0] = cz;
                f[0] = sx;
                g[0] = sz;
                u[1] = cx;
                v[1] = sy;
                w[1] = sz;
                f[1] = sx;
                g[1] = cz;
                f[2] = cx;
                g[2] = cy;
            end
            default:
            begin
                info_next.move = '0;
            end
        endcase
    end

    always_comb
    begin
        ent_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            ent_next[j] = round_sat_q30(pr_reg[j]);
        end
        ent_next[3] = i4_reg.move;
        if (i4_reg.row == mmc_pkg::LAST_ROW)
        begin
            ent_next    = '0;
            ent_next[3] = mmc_pkg::ONE_Q16;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                t_reg[j]   <= u[j] * v[j];
                p_reg[j]   <= f[j] * g[j];
                w_reg[j]   <= w[j];
                rot_reg[j] <= 52'(t_reg[j]) * 52'(w_reg[j]) + (52'(p_reg[j]) <<< 15);
                rq_reg[j]  <= round_q15(rot_reg[j]);
                pr_reg[j]  <= 66'(rq_reg[j]) * 66'($signed(i3_reg.scl[j]));
            end
            i1_reg      <= info_next;
            i2_reg      <= i1_reg;
            i3_reg      <= i2_reg;
            i4_reg      <= i3_reg;
            row_out_reg <= i4_reg.row;
            ent_reg     <= ent_next;
        end
    end

    assign rows.valid     = out_v_reg;
    assign rows.row_index = row_out_reg;
    assign rows.entry_0   = $signed(ent_reg[0]);
    assign rows.entry_1   = $signed(ent_reg[1]);
    assign rows.entry_2   = $signed(ent_reg[2]);
    assign rows.entry_3   = $signed(ent_reg[3]);
    assign rows.final_row = (row_out_reg == mmc_pkg::LAST_ROW);

endmodule

### sv/model_matrix_compose_core.sv
// Top level: builds the 4x4 model matrix T*Rx*Ry*Rz*S, one row per transfer.
//
//  channel | dir | payload
//  --------+-----+---------------------------------------------------
//  items   | in  | angle_x/y/z, move_x/y/z, stretch_x/y/z
//  rows    | out | row_index, entry_0..entry_3, final_row
//
// An item leaves as four row transfers, one per cycle while rows is not
// stalled; the rows block takes a new item only as the last row of the
// previous item issues, as one row datapath sits behind the sequencer. Row 0
// passes 19 trig stages, the operand hold register and 5 row stages.
// Reset clears valid bits and the sequencer; no clearing pass.
// A rows stall freezes row stages, trig once its output waits; nothing drops.
module model_matrix_compose_core (
    input  logic       clk,
    input  logic       rst_n,
    mmc_in_if.sink     items,
    mmc_out_if.source  rows
);

    logic           t_valid;
    logic           t_ready;
    mmc_pkg::trig_t t_data;

    mmc_trig u_trig (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .t_valid (t_valid),
        .t_ready (t_ready),
        .t_data  (t_data)
    );

    mmc_rows u_rows (
        .clk     (clk),
        .rst_n   (rst_n),
        .t_valid (t_valid),
        .t_ready (t_ready),
        .t_data  (t_data),
        .rows    (rows)
    );

endmodule

### sv/mmc_chk.sv
// Port-level checker for the model matrix compose core, bound to the top level.
module mmc_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  row_index,
    input logic [31:0] entry_0,
    input logic [31:0] entry_1,
    input logic [31:0] entry_2,
    input logic [31:0] entry_3,
    input logic        final_row
);

    logic [1:0] exp_row_reg;
    logic [5:0] pend_reg;
    logic       in_xfer;
    logic       out_xfer;
    logic       done;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;
    assign done     = out_xfer && final_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_row_reg <= '0;
            pend_reg    <= '0;
        end
        else
        begin
            if (out_xfer)
            begin
                exp_row_reg <= exp_row_reg + 2'd1;
            end
            pend_reg <= pend_reg + 6'(in_xfer) - 6'(done);
        end
    end

    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> row_index == exp_row_reg)
        else $error("row out of order");

    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && row_index == 2'd3 |->
            final_row && entry_0 == 32'd0 && entry_1 == 32'd0 &&
            entry_2 == 32'd0 && entry_3 == 32'd65536)
        else $error("bad last row");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 6'd0)
        else $error("row without item");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(row_index) &&
            $stable(entry_0) && $stable(entry_3))
        else $error("stalled row changed");

endmodule

bind model_matrix_compose_core mmc_chk u_mmc_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (rows.valid),
    .out_ready (rows.ready),
    .row_index (rows.row_index),
    .entry_0   (rows.entry_0),
    .entry_1   (rows.entry_1),
    .entry_2   (rows.entry_2),
    .entry_3   (rows.entry_3),
    .final_row (rows.final_row)
);

### bench/mmc_tb_if.sv
`timescale 1ns / 100ps
// Testbench constants for the model_matrix_compose_core bench.
package mmc_tb_pkg;
    localparam int ROW_COUNT = 4;
endpackage

### bench/model_matrix_compose_core_tb.sv
`timescale 1ns / 100ps
// Testbench for model_matrix_compose_core: predicts each item's four matrix rows and checks them.
module model_matrix_compose_core_tb;

    typedef struct packed {
        logic signed [15:0] ax, ay, az;
        logic signed [31:0] mx, my, mz;
        logic signed [31:0] kx, ky, kz;
    } item_t;

    typedef struct packed {
        logic [1:0]         row;
        logic signed [31:0] e0, e1, e2, e3;
        logic               last;
    } row_t;

    logic clk;
    logic rst_n;
    mmc_in_if  items ();
    mmc_out_if rows ();

    model_matrix_compose_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .items (items),
        .rows  (rows)
    );

    row_t expected_rows [$];
    int   fail_count;
    int   quiet_cycles;
    bit   send_gaps;
    bit   recv_gaps;
    int   hold_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // rounding shift, half away from zero
    function automatic longint round_shift(longint v, int n);
        longint mag;
        mag = v < 0 ? -v : v;
        mag = (mag + (64'sd1 <<< (n - 1))) >>> n;
        return v < 0 ? -mag : mag;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint sine_quarter(longint r);
        logic [63:0] x, x2, term;
        longint sum;
        x = (64'(r) * 64'd3373259426) / 64'd11520;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int k = 1; k <= 6; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        sum = (sum + 16384) >>> 15;
        return sum > 32767 ? 32767 : sum;
    endfunction

    function automatic void sine_cosine(longint ang, output longint s, output longint c);
        longint a, q, r, sr, cr;
        a = ang % mmc_pkg::FULL_TURN;
        if (a < 0)
            a = a + mmc_pkg::FULL_TURN;
        q = a / mmc_pkg::QUARTER_TURN;
        r = a % mmc_pkg::QUARTER_TURN;
        sr = sine_quarter(r);
        cr = sine_quarter(mmc_pkg::QUARTER_TURN - r);
        case (q)
            0: begin s = sr;  c = cr;  end
            1: begin s = cr;  c = -sr; end
            2: begin s = -sr; c = -cr; end
            default: begin s = -cr; c = sr; end
        endcase
    endfunction

    task automatic compose_rows(item_t it);
        longint sx, cx, sy, cy, sz, cz;
        longint rot [3][3];
        longint scl [3];
        longint mv [3];
        longint e [4];
        row_t rr;
        sine_cosine(it.ax, sx, cx);
        sine_cosine(it.ay, sy, cy);
        sine_cosine(it.az, sz, cz);
        scl[0] = it.kx; scl[1] = it.ky; scl[2] = it.kz;
        mv[0] = it.mx;  mv[1] = it.my;  mv[2] = it.mz;
        rot[0][0] = cy * cz * 32768;
        rot[0][1] = -cy * sz * 32768;
        rot[0][2] = sy * 64'sd1073741824;
        rot[1][0] = sx * sy * cz + cx * sz * 32768;
        rot[1][1] = -sx * sy * sz + cx * cz * 32768;
        rot[1][2] = -sx * cy * 32768;
        rot[2][0] = -cx * sy * cz + sx * sz * 32768;
        rot[2][1] = cx * sy * sz + sx * cz * 32768;
        rot[2][2] = cx * cy * 32768;
        for (int i = 0; i < mmc_tb_pkg::ROW_COUNT; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                if (i == 3)
                    e[j] = (j == 3) ? 65536 : 0;
                else if (j == 3)
                    e[j] = mv[i];
                else
                    e[j] = clamp32(round_shift(round_shift(rot[i][j], 15) * scl[j], 30));
            end
            rr.row = 2'(i);
            rr.e0 = 32'(e[0]);
            rr.e1 = 32'(e[1]);
            rr.e2 = 32'(e[2]);
            rr.e3 = 32'(e[3]);
            rr.last = (i == 3);
            expected_rows.push_back(rr);
        end
    endtask

    // offer one item and return at the edge that transfers it
    task automatic send_item(item_t it);
        if (send_gaps && $urandom_range(99) < 22)
        begin
            items.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 22)
                @(posedge clk);
        end
        compose_rows(it);
        items.valid     <= 1'b1;
        items.angle_x   <= it.ax;
        items.angle_y   <= it.ay;
        items.angle_z   <= it.az;
        items.move_x    <= it.mx;
        items.move_y    <= it.my;
        items.move_z    <= it.mz;
        items.stretch_x <= it.kx;
        items.stretch_y <= it.ky;
        items.stretch_z <= it.kz;
        // ready is settled between the falling and the next rising edge
        @(negedge clk);
        while (!items.ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_angle();
        case ($urandom_range(3))
            0: return 16'($signed($urandom_range(46080)) - 23040);
            1: return 16'($signed($urandom_range(8)) * 2880 - 11520);
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(2880)) - 1440);
        endcase
    endfunction

    function automatic logic signed [31:0] pick_q16();
        case ($urandom_range(3))
            0: return 32'($urandom);
            1: return 32'($signed($urandom_range(8 * 65536)) - 4 * 65536);
            2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return 32'sd65536;
        endcase
    endfunction

    function automatic item_t random_item();
        item_t it;
        it.ax = pick_angle(); it.ay = pick_angle(); it.az = pick_angle();
        it.mx = pick_q16();   it.my = pick_q16();   it.mz = pick_q16();
        it.kx = pick_q16();   it.ky = pick_q16();   it.kz = pick_q16();
        return it;
    endfunction

    task automatic test_identity_and_axes();
        item_t it;
        it = '{16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0,
               32'sd65536, 32'sd65536, 32'sd65536};
        send_item(it);
        for (int q = -4; q <= 4; q++)
        begin
            it.ax = 16'(q * 5760);
            it.ay = 16'(q * 2880);
            it.az = 16'(-q * 5760 + 1);
            send_item(it);
        end
    endtask

    task automatic test_field_extremes();
        item_t it;
        it = '{16'sd23040, -16'sd23040, 16'sh7fff, 32'sh7fffffff, 32'sh80000000,
               32'shffffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
        send_item(it);
        it = '{16'sh8000, 16'sh7fff, 16'sh0000, 32'sh80000000, 32'sh7fffffff,
               32'sh00000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000};
        send_item(it);
        it = '{16'sd23041, -16'sd23041, 16'(46079), 32'sh55555555, 32'shaaaaaaaa,
               32'sd1, 32'sd0, 32'shffffffff, 32'sd1};
        send_item(it);
        it = '{16'sd1440, 16'sd1440, 16'sd1440, 32'shaaaaaaaa, 32'sh55555555,
               32'sd65536, 32'sh7fff0000, 32'sh7fff0000, 32'sh80010000};
        send_item(it);
    endtask

    task automatic test_random_items(int count);
        for (int n = 0; n < count; n++)
        begin
            send_gaps = !(n >= 60 && n < 100);
            send_item(random_item());
        end
        send_gaps = 1'b1;
    endtask

    task automatic test_output_backpressure();
        hold_cycles = 300;
        for (int n = 0; n < 40; n++)
            send_item(random_item());
    endtask

    // receiver: random stalls, plus a long hold when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rows.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            rows.ready <= 1'b0;
        end
        else
            rows.ready <= !recv_gaps || ($urandom_range(99) >= 22);
    end

    always @(posedge clk)
    begin
        row_t want;
        if (rst_n && rows.valid && rows.ready)
        begin
            if (expected_rows.size() == 0)
            begin
                $error("row transfer with nothing expected");
                fail_count++;
            end
            else
            begin
                want = expected_rows.pop_front();
                if (rows.row_index !== want.row)
                begin
                    $error("row_index: expected %0d actual %0d", want.row, rows.row_index);
                    fail_count++;
                end
                if (rows.entry_0 !== want.e0)
                begin
                    $error("entry_0: expected %0d actual %0d", want.e0, rows.entry_0);
                    fail_count++;
                end
                if (rows.entry_1 !== want.e1)
                begin
                    $error("entry_1: expected %0d actual %0d", want.e1, rows.entry_1);
                    fail_count++;
                end
                if (rows.entry_2 !== want.e2)
                begin
                    $error("entry_2: expected %0d actual %0d", want.e2, rows.entry_2);
                    fail_count++;
                end
                if (rows.entry_3 !== want.e3)
                begin
                    $error("entry_3: expected %0d actual %0d", want.e3, rows.entry_3);
                    fail_count++;
                end
                if (rows.final_row !== want.last)
                begin
                    $error("final_row: expected %0d actual %0d", want.last, rows.final_row);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((items.valid && items.ready) || (rows.valid && rows.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        fail_count = 0;
        quiet_cycles = 0;
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        hold_cycles = 0;
        items.valid = 1'b0;
        items.angle_x = '0; items.angle_y = '0; items.angle_z = '0;
        items.move_x = '0;  items.move_y = '0;  items.move_z = '0;
        items.stretch_x = '0; items.stretch_y = '0; items.stretch_z = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_identity_and_axes();
        test_field_extremes();
        test_output_backpressure();
        test_random_items(86);
        recv_gaps = 1'b0;
        test_random_items(40);
        items.valid <= 1'b0;
        recv_gaps = 1'b1;
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

### filelist.f
sv/mmc_pkg.sv
sv/mmc_if.sv
sv/mmc_qsin.sv
sv/mmc_trig.sv
sv/mmc_rows.sv
sv/model_matrix_compose_core.sv
sv/mmc_chk.sv
bench/mmc_tb_if.sv
bench/model_matrix_compose_core_tb.sv
